FILE: hdl/bpsed_pkg.sv
// shared constants, types and symbol decode for the semi-global edit distance block
`timescale 1ns / 1ps
`default_nettype none

package bpsed_pkg;

    // default sizing
    localparam int unsigned WORD_BITS_DEF = 64;
    localparam int unsigned NUM_WORDS_DEF = 4;
    localparam int unsigned MAX_QUERY_DEF = 4095;

    // field widths
    localparam int unsigned OP_W    = 2;
    localparam int unsigned SYM_W   = 8;
    localparam int unsigned SCORE_W = 12;
    localparam int unsigned ST_W    = 2;
    localparam int unsigned CLS_W   = 3;

    localparam int unsigned NUM_CLASSES = 5;
    localparam int unsigned MAX_SCORE   = 4095;

    // request opcodes
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_BADCHAR  = 2'd1;
    localparam logic [ST_W-1:0] ST_CAPACITY = 2'd2;

    // symbol classes
    localparam logic [CLS_W-1:0] CLS_A    = 3'd0;
    localparam logic [CLS_W-1:0] CLS_C    = 3'd1;
    localparam logic [CLS_W-1:0] CLS_G    = 3'd2;
    localparam logic [CLS_W-1:0] CLS_T    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_N    = 3'd4;
    localparam logic [CLS_W-1:0] CLS_NONE = 3'd7;

    localparam logic [SYM_W-1:0] CHAR_A = 8'h41;
    localparam logic [SYM_W-1:0] CHAR_C = 8'h43;
    localparam logic [SYM_W-1:0] CHAR_G = 8'h47;
    localparam logic [SYM_W-1:0] CHAR_T = 8'h54;
    localparam logic [SYM_W-1:0] CHAR_N = 8'h4E;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_Q_PRIME,
        S_Q_RUN,
        S_F_SCAN,
        S_F_OUT
    } t_state;

    function automatic logic [CLS_W-1:0] sym_class(input logic [SYM_W-1:0] s);
        logic [CLS_W-1:0] c;
        case (s)
            CHAR_A:  c = CLS_A;
            CHAR_C:  c = CLS_C;
            CHAR_G:  c = CLS_G;
            CHAR_T:  c = CLS_T;
            CHAR_N:  c = CLS_N;
            default: c = CLS_NONE;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bit_parallel_semiglobal_edit_distance.sv
// top level: bit-parallel semi-global edit distance with a shared word-serial row unit
// load request: accept, match vector read, match vector write; no result
// query request: accept, prime, then one WORD_BITS-wide word of the row per cycle through one adder
// finish request: one column of the final row per cycle from column one, then the output step,
//   or the output step alone after an error or an empty query; result valid the cycle after
// one request at a time; a result still waiting holds a finish in its last cycle
// synchronous active-low reset; finish also returns every store to its reset value at once
`timescale 1ns / 1ps
`default_nettype none

module bit_parallel_semiglobal_edit_distance #(
    parameter int unsigned WORD_BITS = bpsed_pkg::WORD_BITS_DEF,
    parameter int unsigned NUM_WORDS = bpsed_pkg::NUM_WORDS_DEF,
    parameter int unsigned MAX_QUERY = bpsed_pkg::MAX_QUERY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // request channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [bpsed_pkg::OP_W-1:0]    i_op,
    input  wire logic [bpsed_pkg::SYM_W-1:0]   i_symbol,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [bpsed_pkg::SCORE_W-1:0]      o_score,
    output logic [bpsed_pkg::ST_W-1:0]         o_status
);

    import bpsed_pkg::*;

    // sizing
    localparam int unsigned TOT_BITS = WORD_BITS * NUM_WORDS;
    localparam int unsigned REF_CAP  = TOT_BITS - 1;
    localparam int unsigned RL_W     = $clog2(TOT_BITS);
    localparam int unsigned QL_W     = $clog2(MAX_QUERY + 1);
    localparam int unsigned WI_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int unsigned BI_W     = $clog2(WORD_BITS);
    localparam int unsigned MV_DEPTH = NUM_CLASSES * NUM_WORDS;
    localparam int unsigned AW       = $clog2(MV_DEPTH);
    localparam int unsigned BW       = $clog2(TOT_BITS + 1);
    localparam int unsigned SC_W0    = QL_W + BW + 1;
    // wide enough to hold the saturation limit as a signed value
    localparam int unsigned SC_W     = (SC_W0 > SCORE_W + 2) ? SC_W0 : SCORE_W + 2;

    t_state r_state, n_state;

    // match vector memory, one word per class and word index; valid bits make
    // a never-written entry read as zero, and finish clears them all at once
    logic [WORD_BITS-1:0] r_mv_mem [MV_DEPTH];
    logic [MV_DEPTH-1:0]  r_mv_vld;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;

    // row state, diagonal and substitute-or-diagonal class vectors
    logic [WORD_BITS-1:0] r_diag [NUM_WORDS];
    logic [WORD_BITS-1:0] r_sod  [NUM_WORDS];

    // lengths and sticky error
    logic [RL_W-1:0]  r_ref_len;
    logic [WI_W-1:0]  r_pos_word;   // word of the next reference column
    logic [BI_W-1:0]  r_pos_bit;    // bit of the next reference column
    logic [QL_W-1:0]  r_qlen;
    logic [ST_W-1:0]  r_err;

    // sequencer working registers
    logic [CLS_W-1:0] r_cls;
    logic [WI_W-1:0]  r_word;
    logic [BI_W-1:0]  r_bit;
    logic             r_add_c;
    logic             r_c0;
    logic             r_c1;
    logic signed [SC_W-1:0] r_score;
    logic signed [SC_W-1:0] r_best;

    // output register
    logic               r_out_valid;
    logic [SCORE_W-1:0] r_out_score;
    logic [ST_W-1:0]    r_out_status;

    // request decode
    logic [CLS_W-1:0] in_cls;
    logic             cls_ok;
    logic             ref_full;
    logic             q_full;
    logic             in_fire;
    logic             out_free;

    assign in_cls   = sym_class(i_symbol);
    assign cls_ok   = (in_cls != CLS_NONE);
    assign ref_full = (r_ref_len >= RL_W'(REF_CAP));
    assign q_full   = (r_qlen >= QL_W'(MAX_QUERY));
    assign in_fire  = i_in_valid && o_in_ready;
    assign out_free = !r_out_valid || i_out_ready;

    // word and bit counters at their ends
    logic word_last;
    logic bit_last;
    assign word_last = (r_word == WI_W'(NUM_WORDS - 1));
    assign bit_last  = (r_bit == BI_W'(WORD_BITS - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_op)
                        OP_LOAD: begin
                            if (cls_ok && !ref_full) n_state = S_LD_RD;
                        end
                        OP_QUERY: begin
                            if (cls_ok && !q_full) n_state = S_Q_PRIME;
                        end
                        OP_FINISH: begin
                            if (r_err != ST_OK || r_qlen == '0) n_state = S_F_OUT;
                            else n_state = S_F_SCAN;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LD_RD:   n_state = S_LD_WR;
            S_LD_WR:   n_state = S_IDLE;
            S_Q_PRIME: n_state = S_Q_RUN;
            S_Q_RUN: begin
                if (word_last) n_state = S_IDLE;
            end
            S_F_SCAN: begin
                if (word_last && bit_last) n_state = S_F_OUT;
            end
            S_F_OUT: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: ready, memory port control
    logic            mv_rd_en;
    logic            mv_wr_en;
    logic [WI_W-1:0] mv_idx;
    logic [AW-1:0]   mv_addr;

    always_comb begin
        o_in_ready = 1'b0;
        mv_rd_en   = 1'b0;
        mv_wr_en   = 1'b0;
        mv_idx     = r_pos_word;
        case (r_state)
            S_IDLE:    o_in_ready = 1'b1;
            S_LD_RD:   mv_rd_en   = 1'b1;
            S_LD_WR:   mv_wr_en   = 1'b1;
            S_Q_PRIME: begin
                mv_rd_en = 1'b1;
                mv_idx   = '0;
            end
            S_Q_RUN: begin
                // fetch the next word while the current one is worked
                mv_rd_en = 1'b1;
                mv_idx   = r_word + WI_W'(1);
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign mv_addr = AW'(r_cls) * AW'(NUM_WORDS) + AW'(mv_idx);

    // match word as read, never-written entries as zero
    logic [WORD_BITS-1:0] mv_word;
    logic [WORD_BITS-1:0] mv_wr_data;
    assign mv_word    = r_rd_vld ? r_rd_data : '0;
    assign mv_wr_data = mv_word | (WORD_BITS'(1) << r_pos_bit);

    // shared row unit: one word of the class vectors per cycle
    logic [WORD_BITS-1:0] pd, ps, mm, ris, nmi, xv, sr, v0, v1, v0s, v1s;
    logic [WORD_BITS-1:0] new_diag, new_sod;
    logic [WORD_BITS:0]   sum;

    always_comb begin
        pd  = r_diag[r_word];
        ps  = r_sod[r_word];
        mm  = mv_word | pd;
        ris = ~mm;
        nmi = ris | ps;
        xv  = nmi ^ pd;
        // single wide add; the carry chains from word to word
        sum = {1'b0, nmi} + {1'b0, ps} + (WORD_BITS + 1)'(r_add_c);
        sr  = sum[WORD_BITS-1:0] & ris;
        v0  = sr ^ xv;
        v1  = pd | (sr & ps);
        v0s = {v0[WORD_BITS-2:0], r_c0};
        v1s = {v1[WORD_BITS-2:0], r_c1};
        new_diag = mm & v1s;
        new_sod  = v1s | (mm & v0s);
    end

    // final row scan: one column per cycle, running score and minimum
    logic                   sc_pd;
    logic                   sc_pi;
    logic signed [SC_W-1:0] sc_next;
    logic [WORD_BITS-1:0]   sc_diag_word;
    logic [WORD_BITS-1:0]   sc_sod_word;

    always_comb begin
        sc_diag_word = r_diag[r_word];
        sc_sod_word  = r_sod[r_word];
        sc_pd        = sc_diag_word[r_bit];
        sc_pi        = ~sc_sod_word[r_bit];
        case ({sc_pi, sc_pd})
            2'b10:   sc_next = r_score + SC_W'(1);
            2'b01:   sc_next = r_score - SC_W'(1);
            default: sc_next = r_score;
        endcase
    end

    // saturate the minimum to the score range
    logic [SCORE_W-1:0] best_sat;
    always_comb begin
        if (r_best < 0) begin
            best_sat = '0;
        end else if (r_best > $signed(SC_W'(MAX_SCORE))) begin
            best_sat = SCORE_W'(MAX_SCORE);
        end else begin
            best_sat = r_best[SCORE_W-1:0];
        end
    end

    // match vector memory port
    always_ff @(posedge i_clk) begin
        if (mv_wr_en) begin
            r_mv_mem[mv_addr] <= mv_wr_data;
        end
        if (mv_rd_en) begin
            r_rd_data <= r_mv_mem[mv_addr];
            r_rd_vld  <= r_mv_vld[mv_addr];
        end
    end

    // control and block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mv_vld    <= '0;
            for (int k = 0; k < NUM_WORDS; k++) begin
                r_diag[k] <= (k == 0) ? WORD_BITS'(1) : '0;
                r_sod[k]  <= (k == 0) ? WORD_BITS'(1) : '0;
            end
            r_ref_len  <= '0;
            r_pos_word <= '0;
            r_pos_bit  <= BI_W'(1);
            r_qlen     <= '0;
            r_err      <= ST_OK;
        end else begin
            r_state <= n_state;
            // a new result is loaded only once the old one has gone
            if (r_state == S_F_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        case (i_op)
                            OP_LOAD, OP_QUERY: begin
                                // errors are sticky, the first one stays
                                if (!cls_ok) begin
                                    if (r_err == ST_OK) r_err <= ST_BADCHAR;
                                end else if ((i_op == OP_LOAD) ? ref_full : q_full) begin
                                    if (r_err == ST_OK) r_err <= ST_CAPACITY;
                                end else if (i_op == OP_QUERY) begin
                                    r_qlen <= r_qlen + QL_W'(1);
                                end
                            end
                            default: begin
                                r_err <= r_err;
                            end
                        endcase
                    end
                end
                S_LD_WR: begin
                    r_mv_vld[mv_addr] <= 1'b1;
                    r_ref_len         <= r_ref_len + RL_W'(1);
                    if (r_pos_bit == BI_W'(WORD_BITS - 1)) begin
                        r_pos_bit  <= '0;
                        r_pos_word <= r_pos_word + WI_W'(1);
                    end else begin
                        r_pos_bit <= r_pos_bit + BI_W'(1);
                    end
                end
                S_Q_RUN: begin
                    r_diag[r_word] <= new_diag;
                    r_sod[r_word]  <= new_sod;
                end
                S_F_OUT: begin
                    if (out_free) begin
                        // back to the reset picture for the next alignment
                        r_mv_vld <= '0;
                        for (int k = 0; k < NUM_WORDS; k++) begin
                            r_diag[k] <= (k == 0) ? WORD_BITS'(1) : '0;
                            r_sod[k]  <= (k == 0) ? WORD_BITS'(1) : '0;
                        end
                        r_ref_len  <= '0;
                        r_pos_word <= '0;
                        r_pos_bit  <= BI_W'(1);
                        r_qlen     <= '0;
                        r_err      <= ST_OK;
                    end
                end
                default: begin
                    r_err <= r_err;
                end
            endcase
        end
    end

    // working registers and output payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    r_cls   <= in_cls;
                    r_word  <= '0;
                    // scan starts past the zero column
                    r_bit   <= BI_W'(1);
                    r_score <= SC_W'(r_qlen);
                    if (r_err != ST_OK || r_qlen == '0) r_best <= '0;
                    else r_best <= SC_W'(r_qlen);
                end
            end
            S_Q_PRIME: begin
                r_word  <= '0;
                r_add_c <= 1'b0;
                r_c0    <= 1'b0;
                r_c1    <= 1'b1;
            end
            S_Q_RUN: begin
                r_add_c <= sum[WORD_BITS];
                r_c0    <= v0[WORD_BITS-1];
                r_c1    <= v1[WORD_BITS-1];
                r_word  <= r_word + WI_W'(1);
            end
            S_F_SCAN: begin
                r_score <= sc_next;
                if (sc_next < r_best) r_best <= sc_next;
                if (bit_last) begin
                    r_bit  <= '0;
                    r_word <= r_word + WI_W'(1);
                end else begin
                    r_bit <= r_bit + BI_W'(1);
                end
            end
            S_F_OUT: begin
                if (out_free) begin
                    r_out_score  <= best_sat;
                    r_out_status <= r_err;
                end
            end
            default: begin
                r_cls <= r_cls;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_score     = r_out_score;
    assign o_status    = r_out_status;

endmodule

`default_nettype wire

FILE: hdl/bpsed_checker.sv
// port-level checker for the semi-global edit distance block, with its bind
`timescale 1ns / 1ps
`default_nettype none

module bpsed_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic [bpsed_pkg::OP_W-1:0]    i_op,
    input wire logic [bpsed_pkg::SYM_W-1:0]   i_symbol,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [bpsed_pkg::SCORE_W-1:0] o_score,
    input wire logic [bpsed_pkg::ST_W-1:0]    o_status
);

    import bpsed_pkg::*;

    // a request not yet taken stays put
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_op) && $stable(i_symbol))
        else $error("request changed while held off");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_score) && $stable(o_status))
        else $error("result changed while stalled");

    // an error result carries no score
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |-> o_score == '0)
        else $error("error result with nonzero score");

    // only defined status codes leave the block
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_BADCHAR
                         || o_status == ST_CAPACITY))
        else $error("undefined status code");

    // a new result is loaded only while the request side is held off
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without a finish in progress");

endmodule

bind bit_parallel_semiglobal_edit_distance bpsed_checker u_bpsed_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_op        (i_op),
    .i_symbol    (i_symbol),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_score     (o_score),
    .o_status    (o_status)
);

`default_nettype wire

FILE: tb/bit_parallel_semiglobal_edit_distance_tb.sv
// self-checking testbench for the bit-parallel semi-global edit distance block
`timescale 1ns / 1ps

module bit_parallel_semiglobal_edit_distance_tb;
    import bpsed_pkg::*;

    // sizing of the block under test, and of the run
    localparam int WB           = 64;
    localparam int NW           = 4;
    localparam int MAXQ         = 4095;
    localparam int REF_CAP      = NW * WB - 1;
    localparam int RANDOM_ITEMS = 560;
    localparam int CYCLE_LIMIT  = 3_000_000;
    // a finish scans every column past column zero, so the tail outlasts a whole scan
    localparam int TAIL_CYCLES  = NW * WB + 16;

    // opcode that the block ignores
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef logic [WB-1:0] t_word;
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ST_W-1:0]    status;
    } t_result;

    // block ports, all inputs at known values from time zero
    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic [OP_W-1:0]    i_op        = OP_LOAD;
    logic [SYM_W-1:0]   i_symbol    = CHAR_A;
    logic               i_out_ready = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    logic [SCORE_W-1:0] o_score;
    logic [ST_W-1:0]    o_status;

    // run bookkeeping
    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  results_seen   = 0;
    int  requests_sent  = 0;
    int  stall_left     = 0;
    int  finish_count [4];
    bit  idle_on        = 1'b1;

    // predicted state of the aligner
    t_word           match_bits [NUM_CLASSES][NW];
    t_word           diag_vec [NW];
    t_word           subd_vec [NW];
    int              ref_len;
    int              qry_len;
    logic [ST_W-1:0] err_code;
    t_result         expected_scores [$];

    bit_parallel_semiglobal_edit_distance #(
        .WORD_BITS(WB),
        .NUM_WORDS(NW),
        .MAX_QUERY(MAXQ)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_op       (i_op),
        .i_symbol   (i_symbol),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_score    (o_score),
        .o_status   (o_status)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // ------------------------------------------------------------------
    // alignment predictor
    // ------------------------------------------------------------------

    // back to the post-reset picture: empty reference, row zero
    function automatic void clear_alignment();
        int c;
        int j;
        for (c = 0; c < NUM_CLASSES; c++)
            for (j = 0; j < NW; j++)
                match_bits[c][j] = '0;
        for (j = 0; j < NW; j++) begin
            diag_vec[j] = '0;
            subd_vec[j] = '0;
        end
        diag_vec[0][0] = 1'b1;
        subd_vec[0][0] = 1'b1;
        ref_len  = 0;
        qry_len  = 0;
        err_code = ST_OK;
    endfunction

    // nucleotide class of a character, -1 for anything else
    function automatic int base_index(input logic [SYM_W-1:0] s);
        case (s)
            CHAR_A:  return int'(CLS_A);
            CHAR_C:  return int'(CLS_C);
            CHAR_G:  return int'(CLS_G);
            CHAR_T:  return int'(CLS_T);
            CHAR_N:  return int'(CLS_N);
            default: return -1;
        endcase
    endfunction

    // the first error sticks until finish
    function automatic void flag_error(input logic [ST_W-1:0] code);
        if (err_code == ST_OK)
            err_code = code;
    endfunction

    // one row of the score matrix, word by word with chained carries
    function automatic void advance_row(input int cls);
        logic        add_c;
        logic        c0;
        logic        c1;
        logic        h0;
        logic        h1;
        logic [WB:0] sum;
        t_word       pd, ps, mm, ris, nmi, x, sr, v0, v1, v0s, v1s;
        int          j;
        add_c = 1'b0;
        c0    = 1'b0;
        c1    = 1'b1;
        for (j = 0; j < NW; j++) begin
            pd    = diag_vec[j];
            ps    = subd_vec[j];
            mm    = match_bits[cls][j] | pd;
            ris   = ~mm;
            nmi   = ris | ps;
            x     = nmi ^ pd;
            sum   = {1'b0, nmi} + {1'b0, ps} + {{WB{1'b0}}, add_c};
            add_c = sum[WB];
            sr    = sum[WB-1:0] & ris;
            v0    = sr ^ x;
            v1    = pd | (sr & ps);
            h0    = v0[WB-1];
            h1    = v1[WB-1];
            v0s   = {v0[WB-2:0], c0};
            v1s   = {v1[WB-2:0], c1};
            c0    = h0;
            c1    = h1;
            diag_vec[j] = mm & v1s;
            subd_vec[j] = v1s | (mm & v0s);
        end
    endfunction

    // walk the last row from column one and keep the lowest score
    function automatic logic [SCORE_W-1:0] row_minimum();
        int run;
        int best;
        int j;
        int b;
        run  = qry_len;
        best = run;
        for (j = 0; j < NW; j++)
            for (b = 0; b < WB; b++)
                if (j != 0 || b != 0) begin
                    run = run - int'(diag_vec[j][b]) + int'(!subd_vec[j][b]);
                    if (run < best)
                        best = run;
                end
        if (best < 0)
            best = 0;
        if (best > int'(MAX_SCORE))
            best = int'(MAX_SCORE);
        return best[SCORE_W-1:0];
    endfunction

    // effect of one accepted request on the predicted state
    function automatic void predict_request(input logic [OP_W-1:0] op,
                                            input logic [SYM_W-1:0] sym);
        int      cls;
        t_result r;
        cls = base_index(sym);
        case (op)
            OP_LOAD: begin
                if (cls < 0)
                    flag_error(ST_BADCHAR);
                else if (ref_len >= REF_CAP)
                    flag_error(ST_CAPACITY);
                else begin
                    ref_len++;
                    match_bits[cls][ref_len / WB][ref_len % WB] = 1'b1;
                end
            end
            OP_QUERY: begin
                if (cls < 0)
                    flag_error(ST_BADCHAR);
                else if (qry_len >= MAXQ)
                    flag_error(ST_CAPACITY);
                else begin
                    advance_row(cls);
                    qry_len++;
                end
            end
            OP_FINISH: begin
                r.status = err_code;
                r.score  = (err_code == ST_OK && qry_len != 0) ? row_minimum() : '0;
                expected_scores.push_back(r);
                finish_count[err_code]++;
                clear_alignment();
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------

    // mostly ACGT, now and then N
    function automatic logic [SYM_W-1:0] random_base();
        case ($urandom_range(0, 8))
            0, 1:    return CHAR_A;
            2, 3:    return CHAR_C;
            4, 5:    return CHAR_G;
            6, 7:    return CHAR_T;
            default: return CHAR_N;
        endcase
    endfunction

    // present one request, maybe after an idle burst; valid is left high on
    // return so that back-to-back requests never lower it in between
    task automatic send_request(input logic [OP_W-1:0] op, input logic [SYM_W-1:0] sym);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 10);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_symbol   <= sym;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        requests_sent++;
        predict_request(op, sym);
    endtask

    // hold off new requests until every predicted result has come back
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_scores.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // result side: random stalls and the scoreboard
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left  <= $urandom_range(1, 10) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: %s expected %0d got %0d",
                     cycle_count, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (expected_scores.size() == 0) begin
                // a result that no finish request asked for
                report_mismatch("pending results", 0, 1);
            end else begin
                want = expected_scores.pop_front();
                if (o_score !== want.score)
                    report_mismatch("score", want.score, o_score);
                if (o_status !== want.status)
                    report_mismatch("status", want.status, o_status);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    task automatic test_directed();
        // empty query, then an unused opcode which must change nothing
        send_request(OP_FINISH, 8'hFF);
        send_request(OP_SPARE, CHAR_A);
        send_request(OP_FINISH, 8'h00);
        // every class in the reference and in the query
        send_request(OP_LOAD, CHAR_A);
        send_request(OP_LOAD, CHAR_C);
        send_request(OP_LOAD, CHAR_G);
        send_request(OP_LOAD, CHAR_T);
        send_request(OP_LOAD, CHAR_N);
        send_request(OP_QUERY, CHAR_T);
        send_request(OP_QUERY, CHAR_G);
        send_request(OP_QUERY, CHAR_C);
        send_request(OP_QUERY, CHAR_A);
        send_request(OP_QUERY, CHAR_N);
        send_request(OP_FINISH, CHAR_A);
        // reference extended after the query has started
        send_request(OP_QUERY, CHAR_G);
        send_request(OP_LOAD, CHAR_T);
        send_request(OP_QUERY, CHAR_T);
        send_request(OP_FINISH, CHAR_T);
        // bad characters on both request kinds, first one sticks
        send_request(OP_LOAD, 8'h00);
        send_request(OP_QUERY, 8'hFF);
        send_request(OP_FINISH, CHAR_G);
        send_request(OP_QUERY, 8'h61);
        send_request(OP_FINISH, CHAR_C);
        wait_for_results();
    endtask

    task automatic test_reference_capacity();
        int k;
        // reference filled to the last column, then scored
        for (k = 0; k < REF_CAP; k++)
            send_request(OP_LOAD, random_base());
        for (k = 0; k < 3; k++)
            send_request(OP_QUERY, random_base());
        send_request(OP_FINISH, 8'h55);
        // one load too many, then a bad character that must not replace it
        for (k = 0; k <= REF_CAP; k++)
            send_request(OP_LOAD, random_base());
        send_request(OP_QUERY, 8'h7A);
        send_request(OP_FINISH, 8'hAA);
        wait_for_results();
    endtask

    task automatic test_random();
        int               counted;
        int               cases;
        int               ref_n;
        int               qry_n;
        int               qpos;
        int               n;
        bit               mixed;
        bit               derived;
        logic [OP_W-1:0]  op;
        logic [SYM_W-1:0] sym;
        logic [SYM_W-1:0] ref_syms [$];
        counted = 0;
        cases   = 0;
        while (counted < RANDOM_ITEMS) begin
            // last stretch runs flat out on both sides
            if (counted > RANDOM_ITEMS * 4 / 5)
                idle_on = 1'b0;
            if ($urandom_range(0, 6) != 0) begin
                // well-formed alignment: reference, query, finish
                ref_n   = ($urandom_range(0, 15) == 0) ? $urandom_range(17, REF_CAP)
                                                       : $urandom_range(0, 16);
                qry_n   = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 80)
                                                       : $urandom_range(0, 16);
                mixed   = ($urandom_range(0, 4) == 0);
                derived = ($urandom_range(0, 2) != 0);
                qpos    = 0;
                ref_syms.delete();
                while (ref_n + qry_n > 0) begin
                    if (qry_n == 0 || (ref_n > 0 && (!mixed || $urandom_range(0, 1) == 1))) begin
                        sym = random_base();
                        ref_syms.push_back(sym);
                        send_request(OP_LOAD, sym);
                        ref_n--;
                    end else begin
                        // query copied from the reference with sparse edits
                        if (derived && ref_syms.size() > 0 && $urandom_range(0, 4) != 0) begin
                            sym = ref_syms[qpos % ref_syms.size()];
                            qpos++;
                        end else begin
                            sym = random_base();
                        end
                        send_request(OP_QUERY, sym);
                        qry_n--;
                    end
                    counted++;
                end
            end else begin
                // noise: any opcode, any character
                n = $urandom_range(1, 12);
                repeat (n) begin
                    op  = OP_W'($urandom_range(0, 3));
                    sym = $urandom_range(0, 1) ? random_base() : SYM_W'($urandom_range(0, 255));
                    send_request(op, sym);
                    if (op != OP_SPARE)
                        counted++;
                end
            end
            send_request(OP_FINISH, SYM_W'($urandom_range(0, 255)));
            counted++;
            cases++;
            if (cases % 6 == 0)
                wait_for_results();
        end
    endtask

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    initial begin
        finish_count = '{default: 0};
        clear_alignment();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_reference_capacity();
        test_random();

        // drain, then give a late or spurious result time to show up
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("summary: %0d requests over %0d cycles, %0d results checked",
                 requests_sent, cycle_count, results_seen);
        $display("summary: finishes ok %0d, bad symbol %0d, over capacity %0d, mismatches %0d",
                 finish_count[ST_OK], finish_count[ST_BADCHAR], finish_count[ST_CAPACITY],
                 mismatch_count);
        if (mismatch_count == 0 && expected_scores.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
